// ===== design/rv32i_instruction_executor_assert.svh =====
// assertion macros for the rv32i instruction executor
`ifndef RV32I_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define RV32I_INSTRUCTION_EXECUTOR_ASSERT_SVH

// implication checked on every clock edge outside reset
`define RV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never hold outside reset
`define RV_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ===== design/rv32_pkg.sv =====
// shared constants and control types of the rv32i executor
package rv32_pkg;

	localparam int MEM_BYTES_DEF = 131072;
	localparam logic [31:0] HALT_WORD = 32'h0ff00513;

	localparam logic [6:0] OPC_LUI    = 7'b0110111;
	localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
	localparam logic [6:0] OPC_JAL    = 7'b1101111;
	localparam logic [6:0] OPC_JALR   = 7'b1100111;
	localparam logic [6:0] OPC_BRANCH = 7'b1100011;
	localparam logic [6:0] OPC_LOAD   = 7'b0000011;
	localparam logic [6:0] OPC_STORE  = 7'b0100011;
	localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
	localparam logic [6:0] OPC_OP     = 7'b0110011;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_EXEC  = 1'b1;

	typedef struct packed {
		logic       clr;
		logic       latch_in;
		logic       mem_rd;
		logic       mem_wr;
		logic       wsel_store;
		logic       asel_maddr;
		logic [1:0] idx;
		logic       cap_ins;
		logic       cap_ld;
		logic [1:0] cap_idx;
		logic       rf_rd;
		logic       exec;
		logic       commit;
	} rv_cmd_t;

	typedef struct packed {
		logic       halted;
		logic       is_load;
		logic       is_store;
		logic [1:0] last_idx;
		logic       clr_last;
	} rv_stat_t;

endpackage

// ===== design/rv32i_instruction_executor.sv =====
// top level of the rv32i instruction executor
// a byte write passes the memory write state on its way to the result, an execute command runs
// four serial byte fetches from the single-port byte memory, register read, execute,
// up to four serial load or store bytes and commit; execute while halted goes straight to commit
// one item in flight at a time; the next transfer is taken while a result still waits,
// and its commit then stalls until that result is taken
// after reset the byte memory is zeroed by a clear pass over all MEM_BYTES addresses before any transfer
`include "rv32i_instruction_executor_assert.svh"

module rv32i_instruction_executor import rv32_pkg::*; #(
	parameter int MEM_BYTES = MEM_BYTES_DEF // power of two, addresses wrap on it
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [16:0] load_address,
	input  logic [7:0]  load_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] exec_pc,
	output logic        wb_valid,
	output logic [4:0]  wb_index,
	output logic [31:0] wb_value,
	output logic        halted,
	output logic        illegal,
	output logic [7:0]  exit_code
);

	// commands from the controller, status back from the datapath
	rv_cmd_t  ctl;
	rv_stat_t stat;

	// sequencer: clear pass, fetch, register read, execute, memory bytes, commit
	rv32_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.cmd       (cmd),
		.out_ready (out_ready),
		.stat      (stat),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.ctl       (ctl)
	);

	// byte memory, register file, alu and the output register
	rv32_dp #(
		.MEM_BYTES (MEM_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.cmd          (cmd),
		.load_address (load_address),
		.load_byte    (load_byte),
		.stat         (stat),
		.exec_pc      (exec_pc),
		.wb_valid     (wb_valid),
		.wb_index     (wb_index),
		.wb_value     (wb_value),
		.halted       (halted),
		.illegal      (illegal),
		.exit_code    (exit_code)
	);

	// a commit must never overwrite a result that has not been taken
	`RV_ASSERT(a_commit_free, ctl.commit |-> (!out_valid || out_ready), "result overwritten")

	// one memory access a cycle
	`RV_ASSERT_NEVER(a_mem_port, ctl.mem_rd && ctl.mem_wr, "memory read and write together")

	// an illegal stop always reports halted
	`RV_ASSERT(a_ill_halt, out_valid && illegal |-> halted, "illegal without halt")

	// no register write reported means empty write fields
	`RV_ASSERT(a_wb_clean, out_valid && !wb_valid |-> (wb_index == 5'd0 && wb_value == 32'd0),
		"stale write fields")

endmodule

// ===== design/rv32_ctrl.sv =====
// controller state machine of the rv32i executor
module rv32_ctrl import rv32_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     cmd,
	input  logic     out_ready,
	input  rv_stat_t stat,
	output logic     in_ready,
	output logic     out_valid,
	output rv_cmd_t  ctl
);

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_WRB   = 4'd2;
	localparam logic [3:0] ST_FETCH = 4'd3;
	localparam logic [3:0] ST_REGRD = 4'd4;
	localparam logic [3:0] ST_EXEC  = 4'd5;
	localparam logic [3:0] ST_LOAD  = 4'd6;
	localparam logic [3:0] ST_STORE = 4'd7;
	localparam logic [3:0] ST_FIN   = 4'd8;

	logic [3:0] state_q, state_nx;
	logic [2:0] cnt_q, cnt_nx;
	logic       out_valid_q;
	logic [2:0] cnt_m1;
	logic [2:0] last_p1;

	assign cnt_m1  = cnt_q - 3'd1;
	assign last_p1 = {1'b0, stat.last_idx} + 3'd1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		ctl      = '0;
		state_nx = state_q;
		cnt_nx   = cnt_q;
		case (state_q)
			ST_CLEAR: begin
				ctl.clr = 1'b1;
				if (stat.clr_last) state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					ctl.latch_in = 1'b1;
					cnt_nx = 3'd0;
					if (cmd == CMD_WRITE) state_nx = ST_WRB;
					else if (stat.halted) state_nx = ST_FIN;
					else state_nx = ST_FETCH;
				end
			end
			ST_WRB: begin
				ctl.mem_wr = 1'b1;
				state_nx = ST_FIN;
			end
			ST_FETCH: begin
				ctl.mem_rd  = (cnt_q != 3'd4);
				ctl.idx     = cnt_q[1:0];
				ctl.cap_ins = (cnt_q != 3'd0);
				ctl.cap_idx = cnt_m1[1:0];
				cnt_nx = cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					cnt_nx = 3'd0;
					state_nx = ST_REGRD;
				end
			end
			ST_REGRD: begin
				ctl.rf_rd = 1'b1;
				state_nx = ST_EXEC;
			end
			ST_EXEC: begin
				ctl.exec = 1'b1;
				cnt_nx = 3'd0;
				if (stat.is_load) state_nx = ST_LOAD;
				else if (stat.is_store) state_nx = ST_STORE;
				else state_nx = ST_FIN;
			end
			ST_LOAD: begin
				ctl.mem_rd     = (cnt_q != last_p1);
				ctl.asel_maddr = 1'b1;
				ctl.idx        = cnt_q[1:0];
				ctl.cap_ld     = (cnt_q != 3'd0);
				ctl.cap_idx    = cnt_m1[1:0];
				cnt_nx = cnt_q + 3'd1;
				if (cnt_q == last_p1) state_nx = ST_FIN;
			end
			ST_STORE: begin
				ctl.mem_wr     = 1'b1;
				ctl.wsel_store = 1'b1;
				ctl.asel_maddr = 1'b1;
				ctl.idx        = cnt_q[1:0];
				cnt_nx = cnt_q + 3'd1;
				if (cnt_q[1:0] == stat.last_idx) state_nx = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					ctl.commit = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			cnt_q   <= cnt_nx;
			if (ctl.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== design/rv32_dp.sv =====
// datapath of the rv32i executor: memories, alu and result registers
module rv32_dp import rv32_pkg::*; #(
	parameter int MEM_BYTES = MEM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  rv_cmd_t     ctl,
	input  logic        cmd,
	input  logic [16:0] load_address,
	input  logic [7:0]  load_byte,
	output rv_stat_t    stat,
	output logic [31:0] exec_pc,
	output logic        wb_valid,
	output logic [4:0]  wb_index,
	output logic [31:0] wb_value,
	output logic        halted,
	output logic        illegal,
	output logic [7:0]  exit_code
);

	localparam int AW = $clog2(MEM_BYTES);

	logic [7:0]    mem [MEM_BYTES];
	logic [31:0]   rf  [32];
	logic [31:0]   rf_vld_q;

	logic [AW-1:0] clr_q;
	logic          cmd_q, run_q;
	logic [AW-1:0] in_addr_q;
	logic [7:0]    in_byte_q;
	logic [7:0]    rd_q;
	logic [31:0]   ins_q, ld_q;
	logic [31:0]   a_q, b_q;
	logic [31:0]   pc_q, npc_q, res_q;
	logic [AW-1:0] maddr_q;
	logic          wr_q, halt_set_q, ill_set_q;
	logic          halt_q, ill_q;
	logic [7:0]    a0_q;

	logic [AW-1:0] maddr, addr;
	logic [7:0]    wdata;
	logic [6:0]    opc;
	logic [2:0]    f3;
	logic [4:0]    rd, rs1, rs2;
	logic          alt;
	logic [31:0]   immi, imms, immb, immu, immj, op2;
	logic [4:0]    sh;
	logic [31:0]   alu, res_nx, npc_nx;
	logic          wr_nx, bad, take, is_halt, ld_ok, st_ok;
	logic [31:0]   ld_ext, wval;
	logic          wr_fin;

	assign opc = ins_q[6:0];
	assign rd  = ins_q[11:7];
	assign f3  = ins_q[14:12];
	assign rs1 = ins_q[19:15];
	assign rs2 = ins_q[24:20];
	assign alt = ins_q[30];
	assign immi = {{20{ins_q[31]}}, ins_q[31:20]};
	assign imms = {{20{ins_q[31]}}, ins_q[31:25], ins_q[11:7]};
	assign immb = {{19{ins_q[31]}}, ins_q[31], ins_q[7], ins_q[30:25], ins_q[11:8], 1'b0};
	assign immu = {ins_q[31:12], 12'd0};
	assign immj = {{11{ins_q[31]}}, ins_q[31], ins_q[19:12], ins_q[20], ins_q[30:21], 1'b0};

	assign is_halt = (ins_q == HALT_WORD);
	assign ld_ok = (f3 == 3'd0) || (f3 == 3'd1) || (f3 == 3'd2) || (f3 == 3'd4) || (f3 == 3'd5);
	assign st_ok = (f3[2] == 1'b0) && (f3[1:0] != 2'd3);

	assign stat.halted   = halt_q;
	assign stat.is_load  = (opc == OPC_LOAD) && ld_ok;
	assign stat.is_store = (opc == OPC_STORE) && st_ok;
	assign stat.last_idx = (f3[1:0] == 2'd0) ? 2'd0 : ((f3[1:0] == 2'd1) ? 2'd1 : 2'd3);
	assign stat.clr_last = (clr_q == {AW{1'b1}});

	// byte memory port: clearing, byte writes, stores and byte reads
	assign maddr = (ctl.asel_maddr ? maddr_q : pc_q[AW-1:0]) + AW'(ctl.idx);
	assign addr  = ctl.clr ? clr_q : ((ctl.mem_wr && !ctl.wsel_store) ? in_addr_q : maddr);
	assign wdata = ctl.clr ? 8'd0 : (ctl.wsel_store ? b_q[8*ctl.idx +: 8] : in_byte_q);

	always_ff @(posedge clk) begin
		if (ctl.clr || ctl.mem_wr) mem[addr] <= wdata;
		if (ctl.mem_rd) rd_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (ctl.clr) clr_q <= clr_q + AW'(1);
	end

	// alu and next pc
	assign op2 = (opc == OPC_OP) ? b_q : immi;
	assign sh  = op2[4:0];

	always_comb begin
		case (f3)
			3'd0: alu = (opc == OPC_OP && alt) ? a_q - op2 : a_q + op2;
			3'd1: alu = a_q << sh;
			3'd2: alu = {31'd0, $signed(a_q) < $signed(op2)};
			3'd3: alu = {31'd0, a_q < op2};
			3'd4: alu = a_q ^ op2;
			3'd5: alu = alt ? 32'($signed(a_q) >>> sh) : a_q >> sh;
			3'd6: alu = a_q | op2;
			default: alu = a_q & op2;
		endcase
	end

	always_comb begin
		case (f3)
			3'd0: take = (a_q == b_q);
			3'd1: take = (a_q != b_q);
			3'd4: take = $signed(a_q) < $signed(b_q);
			3'd5: take = !($signed(a_q) < $signed(b_q));
			3'd6: take = a_q < b_q;
			3'd7: take = a_q >= b_q;
			default: take = 1'b0;
		endcase
	end

	always_comb begin
		res_nx = alu;
		npc_nx = pc_q + 32'd4;
		wr_nx  = 1'b0;
		bad    = 1'b0;
		if (is_halt) begin
			npc_nx = pc_q;
		end else begin
			case (opc)
				OPC_LUI: begin res_nx = immu; wr_nx = 1'b1; end
				OPC_AUIPC: begin res_nx = pc_q + immu; wr_nx = 1'b1; end
				OPC_JAL: begin
					res_nx = pc_q + 32'd4; wr_nx = 1'b1; npc_nx = pc_q + immj;
				end
				OPC_JALR: begin
					res_nx = pc_q + 32'd4; wr_nx = 1'b1;
					npc_nx = (a_q + immi) & ~32'd1;
				end
				OPC_BRANCH: begin
					bad = (f3 == 3'd2) || (f3 == 3'd3);
					if (take) npc_nx = pc_q + immb;
				end
				OPC_LOAD: begin wr_nx = ld_ok; bad = !ld_ok; end
				OPC_STORE: bad = !st_ok;
				OPC_OPIMM, OPC_OP: wr_nx = 1'b1;
				default: bad = 1'b1;
			endcase
			if (bad) begin
				npc_nx = pc_q;
				wr_nx  = 1'b0;
			end
		end
	end

	always_comb begin
		case (f3)
			3'd0: ld_ext = {{24{ld_q[7]}}, ld_q[7:0]};
			3'd1: ld_ext = {{16{ld_q[15]}}, ld_q[15:0]};
			3'd4: ld_ext = {24'd0, ld_q[7:0]};
			3'd5: ld_ext = {16'd0, ld_q[15:0]};
			default: ld_ext = ld_q;
		endcase
	end

	assign wr_fin = run_q && wr_q && (rd != 5'd0);
	assign wval   = (opc == OPC_LOAD) ? ld_ext : res_q;

	// work registers
	always_ff @(posedge clk) begin
		if (ctl.latch_in) begin
			cmd_q     <= cmd;
			run_q     <= (cmd == CMD_EXEC) && !halt_q;
			in_addr_q <= AW'(load_address);
			in_byte_q <= load_byte;
			ld_q      <= 32'd0;
		end
		if (ctl.cap_ins) ins_q[8*ctl.cap_idx +: 8] <= rd_q;
		if (ctl.cap_ld) ld_q[8*ctl.cap_idx +: 8] <= rd_q;
		if (ctl.rf_rd) begin
			a_q <= rf_vld_q[rs1] ? rf[rs1] : 32'd0;
			b_q <= rf_vld_q[rs2] ? rf[rs2] : 32'd0;
		end
		if (ctl.exec) begin
			res_q      <= res_nx;
			npc_q      <= npc_nx;
			wr_q       <= wr_nx;
			halt_set_q <= is_halt || bad;
			ill_set_q  <= bad;
			maddr_q    <= AW'(a_q + ((opc == OPC_STORE) ? imms : immi));
		end
		if (ctl.commit && wr_fin) rf[rd] <= wval;
		if (ctl.commit) begin
			exec_pc  <= (cmd_q == CMD_EXEC) ? pc_q : 32'd0;
			wb_valid <= wr_fin;
			wb_index <= wr_fin ? rd : 5'd0;
			wb_value <= wr_fin ? wval : 32'd0;
		end
	end

	// architectural state with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= 32'd0;
			pc_q     <= 32'd0;
			halt_q   <= 1'b0;
			ill_q    <= 1'b0;
			a0_q     <= 8'd0;
		end else if (ctl.commit && run_q) begin
			pc_q <= npc_q;
			if (halt_set_q) halt_q <= 1'b1;
			if (ill_set_q) ill_q <= 1'b1;
			if (wr_fin) begin
				rf_vld_q[rd] <= 1'b1;
				if (rd == 5'd10) a0_q <= wval[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted    <= 1'b0;
			illegal   <= 1'b0;
			exit_code <= 8'd0;
		end else if (ctl.commit) begin
			halted    <= halt_q || (run_q && halt_set_q);
			illegal   <= ill_q || (run_q && ill_set_q);
			exit_code <= (halt_q || (run_q && halt_set_q)) ? a0_q : 8'd0;
		end
	end

endmodule
